// File: hdl/pulse_record_framer_crc16_macros.svh
// ----------------------------------------------------------------------------
// Pulse record framer assertion macros
// Property shorthands for the framer port checker.
// ----------------------------------------------------------------------------
`ifndef PULSE_RECORD_FRAMER_CRC16_MACROS_SVH
`define PULSE_RECORD_FRAMER_CRC16_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define PRF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define PRF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/prf_pkg.sv
// ----------------------------------------------------------------------------
// Pulse record framer package
// Item types, frame constants and the CRC-16 byte update.
// ----------------------------------------------------------------------------
package prf_pkg;

  // One input request.
  typedef struct packed {
    logic        frame_start;
    logic [7:0]  pulse_count;
    logic        has_pulse;
    logic [15:0] start_ticks;
    logic [15:0] width_ticks;
    logic        frame_end;
  } in_item_t;

  // One result byte.
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
    logic       frame_done;
  } out_item_t;

  // Classified work for the byte serializer.
  typedef struct packed {
    logic        do_hdr;
    logic [7:0]  count;
    logic        do_pulse;
    logic [15:0] t0;
    logic [15:0] dur;
    logic        do_end;
  } cmd_t;

  localparam int CMD_DEPTH = 2;
  localparam int OUT_DEPTH = 2;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [7:0]  SYNC_BYTE = 8'hFF;

  // Byte slots that follow the preamble, counted from its end.
  localparam logic [2:0] OFS_COUNT  = 3'd0;
  localparam logic [2:0] OFS_SYNC   = 3'd1;
  localparam logic [2:0] OFS_T0_LO  = 3'd2;
  localparam logic [2:0] OFS_T0_HI  = 3'd3;
  localparam logic [2:0] OFS_DUR_LO = 3'd4;
  localparam logic [2:0] OFS_DUR_HI = 3'd5;
  localparam logic [2:0] OFS_CRC_LO = 3'd6;
  localparam logic [2:0] OFS_CRC_HI = 3'd7;

  localparam int PRE_TABLE_LEN = 7;
  localparam logic [7:0] PRE_TABLE [PRE_TABLE_LEN] = '{
    8'h45, 8'h43, 8'h48, 8'hF4, 8'h50, 8'h52, 8'h45
  };

  // Preamble byte at a position; positions past the table send zero.
  function automatic logic [7:0] prf_preamble(input logic [7:0] idx);
    logic [7:0] b;
    b = 8'h00;
    if (idx < 8'(PRE_TABLE_LEN)) begin
      b = PRE_TABLE[idx[2:0]];
    end
    return b;
  endfunction

  // CRC-16/CCITT-FALSE over one byte, MSB first.
  function automatic logic [15:0] prf_crc_update(input logic [15:0] crc,
                                                 input logic [7:0]  b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: hdl/pulse_record_framer_crc16.sv
// ----------------------------------------------------------------------------
// Pulse record framer with CRC-16 trailer
// Turns pulse record requests into the bytes of a framed, CRC-checked stream.
// ----------------------------------------------------------------------------
// Each accepted request produces one output byte per clock unless the output
// queue is full: a frame_start request sends PREAMBLE_LENGTH preamble bytes,
// the pulse count and 0xFF; a pulse request sends start time and duration,
// low byte first (4 bytes); a closing request sends the CRC-16/CCITT-FALSE of
// the frame, low byte first. A request occupies the byte serializer until its
// last byte is sent (4 bytes for a pulse, up to PREAMBLE_LENGTH + 8 for one
// that does everything), and that one-byte-per-cycle serializer sets the rate.
// Pulse and end flags are honored only while a frame is open, counting one
// opened by the same request; frame_start on an open frame restarts it.
// A two-entry queue sits between request classification and the serializer,
// so new requests are taken while earlier ones are still being sent, and a
// two-entry output queue lets the serializer keep going while a byte waits.
// Requests that produce no byte are absorbed without output.
module pulse_record_framer_crc16 import prf_pkg::*; #(
  parameter int PREAMBLE_LENGTH = 7
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  input  in_item_t  in_item,
  output logic      in_full,
  input  logic      out_pop,
  output out_item_t out_item,
  output logic      out_empty
);

  logic      cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t      cmd_wr, cmd_rd;
  logic      ob_push, ob_full;
  out_item_t ob_data;

  // Front end: frame tracking and request classification.
  prf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_item  (in_item),
    .in_full  (in_full),
    .cmd_push (cmd_push),
    .cmd_data (cmd_wr),
    .cmd_full (cmd_full)
  );

  // Work queue; the head stays until its last byte is sent.
  prf_fifo #(
    .item_t (cmd_t),
    .DEPTH  (CMD_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (cmd_push),
    .wr_data (cmd_wr),
    .full    (cmd_full),
    .pop     (cmd_pop),
    .rd_data (cmd_rd),
    .empty   (cmd_empty)
  );

  // Back end: byte sequencing and running CRC.
  prf_back #(
    .PREAMBLE_LENGTH (PREAMBLE_LENGTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd_rd),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .ob_push   (ob_push),
    .ob_data   (ob_data),
    .ob_full   (ob_full)
  );

  // Output queue presented on the result ports.
  prf_fifo #(
    .item_t (out_item_t),
    .DEPTH  (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (ob_push),
    .wr_data (ob_data),
    .full    (ob_full),
    .pop     (out_pop),
    .rd_data (out_item),
    .empty   (out_empty)
  );

endmodule

// File: hdl/prf_fifo.sv
// ----------------------------------------------------------------------------
// Pulse record framer queue
// Small register queue used between the framer stages and at the output.
// ----------------------------------------------------------------------------
module prf_fifo #(
  parameter type item_t = logic,
  parameter int  DEPTH  = 2
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t wr_data,
  output logic  full,
  input  logic  pop,
  output item_t rd_data,
  output logic  empty
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  item_t            mem_r [DEPTH];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             wr_en, rd_en;

  assign full    = (cnt_r == CntW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign wr_en   = push && !full;
  assign rd_en   = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// File: hdl/prf_front.sv
// ----------------------------------------------------------------------------
// Pulse record framer front end
// Accepts requests, tracks whether a frame is open and queues the work.
// ----------------------------------------------------------------------------
module prf_front import prf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  input  in_item_t  in_item,
  output logic      in_full,
  output logic      cmd_push,
  output cmd_t      cmd_data,
  input  logic      cmd_full
);

  logic frame_open_r, frame_open_nxt;
  logic open_eff;
  logic accept;

  // A request with frame_start opens the frame before its pulse and end parts.
  assign open_eff = frame_open_r || in_item.frame_start;
  assign in_full  = cmd_full;
  assign accept   = in_push && !cmd_full;

  always_comb begin
    cmd_data.do_hdr   = in_item.frame_start;
    cmd_data.count    = in_item.pulse_count;
    cmd_data.do_pulse = open_eff && in_item.has_pulse;
    cmd_data.t0       = in_item.start_ticks;
    cmd_data.dur      = in_item.width_ticks;
    cmd_data.do_end   = open_eff && in_item.frame_end;
  end

  // Requests that produce no byte never reach the serializer.
  assign cmd_push = accept && (cmd_data.do_hdr || cmd_data.do_pulse || cmd_data.do_end);

  always_comb begin
    frame_open_nxt = frame_open_r;
    if (accept) begin
      frame_open_nxt = cmd_data.do_end ? 1'b0 : open_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_open_r <= 1'b0;
    end else begin
      frame_open_r <= frame_open_nxt;
    end
  end

endmodule

// File: hdl/prf_back.sv
// ----------------------------------------------------------------------------
// Pulse record framer back end
// Serializes queued work into frame bytes and keeps the running CRC.
// ----------------------------------------------------------------------------
module prf_back import prf_pkg::*; #(
  parameter int PREAMBLE_LENGTH = 7
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      cmd,
  input  logic      cmd_empty,
  output logic      cmd_pop,
  output logic      ob_push,
  output out_item_t ob_data,
  input  logic      ob_full
);

  localparam int PosW = $clog2(PREAMBLE_LENGTH + 8);
  localparam logic [PosW-1:0] PrePos   = PosW'(PREAMBLE_LENGTH);
  localparam logic [PosW-1:0] PulsePos = PosW'(PREAMBLE_LENGTH + 2);
  localparam logic [PosW-1:0] CrcPos   = PosW'(PREAMBLE_LENGTH + 6);

  logic [PosW-1:0] pos_r, pos_nxt;
  logic [PosW-1:0] pos_cur, start_pos;
  logic            first_r, first_nxt;
  logic [15:0]     crc_r, crc_nxt, crc_base;
  logic            fire, in_pre, done, is_data;
  logic [2:0]      ofs;
  logic [7:0]      byte_val;

  assign fire      = !cmd_empty && !ob_full;
  assign start_pos = cmd.do_hdr ? '0 : (cmd.do_pulse ? PulsePos : CrcPos);
  assign pos_cur   = first_r ? start_pos : pos_r;
  assign in_pre    = (pos_cur < PrePos);
  assign ofs       = 3'(pos_cur - PrePos);
  // A new header restarts the CRC at its first preamble byte.
  assign crc_base  = (cmd.do_hdr && pos_cur == '0) ? CRC_INIT : crc_r;

  always_comb begin
    byte_val = 8'h00;
    done     = 1'b0;
    is_data  = 1'b1;
    pos_nxt  = pos_cur + 1'b1;
    if (in_pre) begin
      byte_val = prf_preamble(8'(pos_cur));
    end else begin
      case (ofs)
        OFS_COUNT:  byte_val = cmd.count;
        OFS_SYNC: begin
          byte_val = SYNC_BYTE;
          if (!cmd.do_pulse) begin
            pos_nxt = CrcPos;
            done    = !cmd.do_end;
          end
        end
        OFS_T0_LO:  byte_val = cmd.t0[7:0];
        OFS_T0_HI:  byte_val = cmd.t0[15:8];
        OFS_DUR_LO: byte_val = cmd.dur[7:0];
        OFS_DUR_HI: begin
          byte_val = cmd.dur[15:8];
          done     = !cmd.do_end;
        end
        OFS_CRC_LO: begin
          byte_val = crc_r[7:0];
          is_data  = 1'b0;
        end
        OFS_CRC_HI: begin
          byte_val = crc_r[15:8];
          is_data  = 1'b0;
          done     = 1'b1;
        end
        default: byte_val = 8'h00;
      endcase
    end
  end

  always_comb begin
    crc_nxt   = crc_r;
    first_nxt = first_r;
    if (fire) begin
      first_nxt = done;
      if (is_data) begin
        crc_nxt = prf_crc_update(crc_base, byte_val);
      end else if (done) begin
        crc_nxt = CRC_INIT;
      end
    end
  end

  assign cmd_pop            = fire && done;
  assign ob_push            = fire;
  assign ob_data.frame_byte = byte_val;
  assign ob_data.last_byte  = done;
  assign ob_data.frame_done = !in_pre && (ofs == OFS_CRC_HI);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      first_r <= 1'b1;
      crc_r   <= CRC_INIT;
    end else begin
      if (fire) begin
        pos_r <= pos_nxt;
      end
      first_r <= first_nxt;
      crc_r   <= crc_nxt;
    end
  end

endmodule

// File: hdl/prf_checker.sv
// ----------------------------------------------------------------------------
// Pulse record framer port checker
// Watches the top-level ports of the framer for ordering and handshake slips.
// ----------------------------------------------------------------------------
`include "pulse_record_framer_crc16_macros.svh"

module prf_checker import prf_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_push,
  input in_item_t  in_item,
  input logic      in_full,
  input logic      out_pop,
  input out_item_t out_item,
  input logic      out_empty
);

  // The closing CRC byte always ends the request that caused it.
  `PRF_ASSERT_NOW(a_done_is_last, !out_empty && out_item.frame_done, out_item.last_byte, "frame_done without last_byte")

  // A full work queue means the serializer has already produced output.
  `PRF_ASSERT_NOW(a_full_has_output, in_full, !out_empty, "input full while no byte is waiting")

  // A waiting byte stays put until it is taken.
  `PRF_ASSERT_NEXT(a_out_hold, !out_empty && !out_pop, !out_empty && $stable(out_item), "waiting result changed before pop")

endmodule

bind pulse_record_framer_crc16 prf_checker u_prf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_push   (in_push),
  .in_item   (in_item),
  .in_full   (in_full),
  .out_pop   (out_pop),
  .out_item  (out_item),
  .out_empty (out_empty)
);

// File: sim/prf_frame_checker.sv
// ----------------------------------------------------------------------------
// Pulse record framer checker
// Watches both queue ports of the framer, predicts every frame byte from the
// accepted requests and compares each popped byte against the prediction.
// ----------------------------------------------------------------------------
module prf_frame_checker import prf_pkg::*; #(
  parameter int PREAMBLE_LENGTH = 7
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  input  in_item_t  in_item,
  input  logic      in_full,
  input  logic      out_pop,
  input  out_item_t out_item,
  input  logic      out_empty,
  output int        fail_count,
  output int        pending
);

  localparam logic [7:0] PREAMBLE_BYTES [7] = '{
    8'h45, 8'h43, 8'h48, 8'hF4, 8'h50, 8'h52, 8'h45
  };

  logic [15:0] frame_crc = CRC_INIT;
  logic        frame_open = 1'b0;
  out_item_t   expected_bytes [$];

  // CRC-16/CCITT-FALSE, one data bit at a time, MSB first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                             input logic [7:0]  data);
    logic [15:0] c;
    logic        feedback;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      feedback = c[15] ^ data[i];
      c = {c[14:0], 1'b0};
      if (feedback) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  task automatic add_byte(input logic [7:0] data, input logic done,
                          input logic counted);
    out_item_t b;
    b.frame_byte = data;
    b.last_byte  = 1'b0;
    b.frame_done = done;
    expected_bytes.insert(expected_bytes.size(), b);
    if (counted) begin
      frame_crc = crc16_byte(frame_crc, data);
    end
  endtask

  // Header first, then the pulse record, then the CRC trailer.
  task automatic predict_frame_bytes(input in_item_t req);
    int        first;
    out_item_t tail;
    logic [15:0] crc_snap;
    first = expected_bytes.size();
    if (req.frame_start) begin
      frame_crc  = CRC_INIT;
      frame_open = 1'b1;
      for (int i = 0; i < PREAMBLE_LENGTH; i++) begin
        add_byte((i < 7) ? PREAMBLE_BYTES[3'(i)] : 8'h00, 1'b0, 1'b1);
      end
      add_byte(req.pulse_count, 1'b0, 1'b1);
      add_byte(SYNC_BYTE, 1'b0, 1'b1);
    end
    if (frame_open && req.has_pulse) begin
      add_byte(req.start_ticks[7:0], 1'b0, 1'b1);
      add_byte(req.start_ticks[15:8], 1'b0, 1'b1);
      add_byte(req.width_ticks[7:0], 1'b0, 1'b1);
      add_byte(req.width_ticks[15:8], 1'b0, 1'b1);
    end
    if (frame_open && req.frame_end) begin
      crc_snap = frame_crc;
      add_byte(crc_snap[7:0], 1'b0, 1'b0);
      add_byte(crc_snap[15:8], 1'b1, 1'b0);
      frame_crc  = CRC_INIT;
      frame_open = 1'b0;
    end
    if (expected_bytes.size() > first) begin
      tail = expected_bytes.pop_back();
      tail.last_byte = 1'b1;
      expected_bytes.insert(expected_bytes.size(), tail);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      frame_crc  = CRC_INIT;
      frame_open = 1'b0;
      expected_bytes.delete();
    end else begin
      if (in_push && !in_full) begin
        predict_frame_bytes(in_item);
      end
      if (out_pop && !out_empty) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected byte, expected none, actual %02h last %b done %b",
                   $time, out_item.frame_byte, out_item.last_byte, out_item.frame_done);
          fail_count = fail_count + 1;
        end else begin
          want = expected_bytes.pop_front();
          if (out_item.frame_byte !== want.frame_byte) begin
            $display("%0t: frame_byte mismatch, expected %02h, actual %02h",
                     $time, want.frame_byte, out_item.frame_byte);
            fail_count = fail_count + 1;
          end
          if (out_item.last_byte !== want.last_byte) begin
            $display("%0t: last_byte mismatch, expected %b, actual %b",
                     $time, want.last_byte, out_item.last_byte);
            fail_count = fail_count + 1;
          end
          if (out_item.frame_done !== want.frame_done) begin
            $display("%0t: frame_done mismatch, expected %b, actual %b",
                     $time, want.frame_done, out_item.frame_done);
            fail_count = fail_count + 1;
          end
        end
      end
    end
    pending = expected_bytes.size();
  end

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// Pulse record framer testbench
// Drives directed and random pulse record requests into the framer with
// random gaps on the request side and random stalls on the byte side; the
// checker beside the block predicts and compares every byte of every frame.
// ----------------------------------------------------------------------------
module testbench;
  import prf_pkg::*;

  localparam int PREAMBLE_LENGTH = 7;
  // The slowest correct run stays well below this: some 350 requests of at
  // most fifteen bytes each, with every byte waiting out at most one longest
  // stall on the byte side.
  localparam int CYCLE_LIMIT     = 2000000;
  localparam int DRAIN_CYCLES    = 40;
  localparam int TOTAL_REQUESTS  = 330;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_push = 1'b0;
  in_item_t  in_item = '0;
  logic      in_full;
  logic      out_pop = 1'b0;
  out_item_t out_item;
  logic      out_empty;

  int fail_count;
  int pending;
  int cycle_count = 0;

  // Number of requests handed to the block so far.
  int   sent = 0;
  // While calm is set the request side sends back to back.
  bit   calm = 1'b0;

  always #5 clk = ~clk;

  pulse_record_framer_crc16 #(
    .PREAMBLE_LENGTH(PREAMBLE_LENGTH)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_item  (in_item),
    .in_full  (in_full),
    .out_pop  (out_pop),
    .out_item (out_item),
    .out_empty(out_empty)
  );

  prf_frame_checker #(
    .PREAMBLE_LENGTH(PREAMBLE_LENGTH)
  ) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_item   (in_item),
    .in_full   (in_full),
    .out_pop   (out_pop),
    .out_item  (out_item),
    .out_empty (out_empty),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // A hung handshake or a lost byte ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic in_item_t make_item(input bit start, input logic [7:0] count,
                                         input bit pulse, input logic [15:0] t0,
                                         input logic [15:0] dur, input bit fin);
    in_item_t it;
    it.frame_start = start;
    it.pulse_count = count;
    it.has_pulse   = pulse;
    it.start_ticks = t0;
    it.width_ticks = dur;
    it.frame_end   = fin;
    return it;
  endfunction

  // Most gaps are zero or short; now and then a long one lets the block
  // drain completely before the next request.
  function automatic int idle_cycles(input int long_max);
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 88) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, long_max);
  endfunction

  // Offers one request and returns at the edge where the block takes it.
  // in_push is lowered only when a gap is taken, so a back to back request
  // keeps it high without a second assignment in the same step.
  task automatic send_request(input in_item_t it);
    int gap;
    gap = calm ? 0 : idle_cycles(30);
    sent = sent + 1;
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_full) begin
      @(posedge clk);
    end
  endtask

  task automatic send_pulse(input bit fin);
    send_request(make_item(1'b0, 8'($urandom), 1'b1, 16'($urandom), 16'($urandom), fin));
  endtask

  // Byte side: bursts of pops separated by stalls of random length, with
  // many zero stalls so that long stretches pop every cycle.
  initial begin
    int stall;
    @(posedge clk);
    forever begin
      stall = idle_cycles(40);
      if (stall > 0) begin
        out_pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_pop <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  initial begin
    int  n_pulses;
    int  r;
    bit  merge_first;
    bit  merge_last;
    bit  abandon;
    logic [7:0] count;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Pulse and end with no open frame are dropped, as is
    // an empty request, both outside and inside a frame.
    send_request(make_item(1'b0, 8'h00, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1));
    send_request(make_item(1'b0, 8'h00, 1'b0, 16'h0000, 16'h0000, 1'b0));
    send_request(make_item(1'b1, 8'h00, 1'b0, 16'h0000, 16'h0000, 1'b0));
    send_request(make_item(1'b0, 8'hFF, 1'b1, 16'h0000, 16'h0000, 1'b0));
    send_request(make_item(1'b0, 8'h00, 1'b1, 16'hFFFF, 16'hFFFF, 1'b0));
    send_request(make_item(1'b0, 8'h00, 1'b1, 16'h00FF, 16'hFF00, 1'b0));
    send_request(make_item(1'b0, 8'h00, 1'b0, 16'hFFFF, 16'hFFFF, 1'b0));
    send_request(make_item(1'b0, 8'h00, 1'b0, 16'h0000, 16'h0000, 1'b1));
    // A second close after the frame is done produces nothing.
    send_request(make_item(1'b0, 8'h00, 1'b0, 16'h0000, 16'h0000, 1'b1));
    // Everything in one request: the longest byte burst a request can make.
    send_request(make_item(1'b1, 8'hFF, 1'b1, 16'h1234, 16'hABCD, 1'b1));
    // Restart while a frame is open throws away the old running CRC.
    send_request(make_item(1'b1, 8'hA5, 1'b1, 16'h8001, 16'h7FFE, 1'b0));
    send_request(make_item(1'b1, 8'h5A, 1'b0, 16'h0000, 16'h0000, 1'b0));
    send_request(make_item(1'b0, 8'h00, 1'b1, 16'h5555, 16'hAAAA, 1'b0));
    send_request(make_item(1'b0, 8'h00, 1'b1, 16'hAAAA, 16'h5555, 1'b1));
    // The count in the header need not match the pulses that follow.
    send_request(make_item(1'b1, 8'h03, 1'b0, 16'h0000, 16'h0000, 1'b1));
    send_request(make_item(1'b1, 8'h02, 1'b0, 16'h0000, 16'h0000, 1'b0));
    send_request(make_item(1'b0, 8'h00, 1'b1, 16'hFFFF, 16'h0000, 1'b1));

    // Random part: mostly well formed frames with random content, plus
    // noise requests and frames that are abandoned by a restart.
    while (sent < TOTAL_REQUESTS) begin
      calm = ($urandom_range(0, 7) == 0);
      r = $urandom_range(0, 99);
      if (r < 15) begin
        repeat ($urandom_range(1, 4)) begin
          send_request(make_item($urandom_range(0, 3) == 0, 8'($urandom),
                                 1'($urandom), 16'($urandom), 16'($urandom),
                                 1'($urandom)));
        end
      end else begin
        n_pulses = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24)
                                                : $urandom_range(0, 6);
        count = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'(n_pulses);
        merge_first = ($urandom_range(0, 2) == 0) && (n_pulses > 0);
        merge_last  = ($urandom_range(0, 1) == 0) && (n_pulses > (merge_first ? 1 : 0));
        abandon     = ($urandom_range(0, 9) == 0);
        send_request(make_item(1'b1, count, merge_first, 16'($urandom),
                               16'($urandom), 1'b0));
        for (int i = (merge_first ? 1 : 0); i < n_pulses; i++) begin
          if ($urandom_range(0, 19) == 0) begin
            send_request(make_item(1'b0, 8'($urandom), 1'b0, 16'($urandom),
                                   16'($urandom), 1'b0));
          end
          send_pulse(!abandon && merge_last && (i == n_pulses - 1));
        end
        if (!abandon && !merge_last) begin
          send_request(make_item(1'b0, 8'($urandom), 1'b0, 16'($urandom),
                                 16'($urandom), 1'b1));
        end
      end
    end
    in_push <= 1'b0;

    // Wait on the falling edge so that the checker's bookkeeping for the
    // last rising edge is settled, then give stray bytes time to show up.
    @(negedge clk);
    while (pending != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
